// ===== rtl/hhcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_pkg: shared types and constants of the hodoscope hit coincidence counter
// Request and result payloads, the classified operation between front and
// back end, the register set and the fixed detector geometry.
// ----------------------------------------------------------------------------
package hhcc_pkg;

	// Width of a segment or tile index inside the block
	localparam int IDX_W = 6;

	// Depths of the operation queue and of the result queue
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// Geometry in units of 1/16 mm: pitch 14 mm, offset 10 mm
	localparam int PITCH16  = 224;
	localparam int OFFSET16 = 160;
	// pitch = 7 << 5; floor(v / 7) = (v * 293) >> 11 for v < 224
	localparam int PITCH_SHIFT = 5;
	localparam logic [8:0] DIV7_MUL = 9'd293;
	localparam int DIV7_SHIFT = 11;

	// Tiles that take part in the coincidence flags
	localparam int TILE_PAIR_LO_A = 20;
	localparam int TILE_PAIR_LO_B = 21;
	localparam int TILE_PAIR_HI_A = 22;
	localparam int TILE_PAIR_HI_B = 23;
	localparam int TILE_EDGE_LAST = 5;

	// Register indexes (byte address 4 * index)
	localparam logic [1:0] REG_SEGMENT_LOW  = 2'd0;
	localparam logic [1:0] REG_SEGMENT_HIGH = 2'd1;
	localparam logic [1:0] REG_BEAM_THRESH  = 2'd2;
	localparam logic [1:0] REG_TILE_THRESH  = 2'd3;

	localparam logic [3:0]  RST_SEGMENT_LOW  = 4'd4;
	localparam logic [3:0]  RST_SEGMENT_HIGH = 4'd10;
	localparam logic [15:0] RST_BEAM_THRESH  = 16'd100;
	localparam logic [15:0] RST_TILE_THRESH  = 16'd200;

	// Operation codes from the front end
	typedef logic [1:0] op_kind_t;
	localparam op_kind_t OP_NONE = 2'd0;
	localparam op_kind_t OP_SEG  = 2'd1;
	localparam op_kind_t OP_TILE = 2'd2;

	typedef struct packed {
		logic               detector;
		logic signed [19:0] x_position;
		logic [5:0]         tile_number;
		logic [15:0]        energy_kev;
		logic               hit_present;
		logic               event_last;
	} hit_t;

	typedef struct packed {
		logic        event_selected;
		logic        multiplicity_two;
		logic        pair_twenty;
		logic        pair_twentytwo;
		logic        edge_single;
		logic [5:0]  tile_multiplicity;
		logic [31:0] count_selected;
		logic [31:0] count_multiplicity;
		logic [31:0] count_pair_low;
		logic [31:0] count_pair_high;
		logic [31:0] count_edge;
	} result_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [IDX_W-1:0] index;
		logic [15:0]      energy;
		logic             last;
	} op_t;

	typedef struct packed {
		logic [3:0]  segment_low;
		logic [3:0]  segment_high;
		logic [15:0] beam_threshold_kev;
		logic [15:0] tile_threshold_kev;
	} cfg_t;

	function automatic logic one_of_four(input logic [3:0] v);
		logic r;
		case (v)
			4'b0001, 4'b0010, 4'b0100, 4'b1000: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/hhcc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_fifo: small register queue
// First-in first-out queue with the head entry shown on rdata while not empty.
// ----------------------------------------------------------------------------
module hhcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     count
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/hhcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_front: hit classifier
// Maps a beam-counter position to its segment and checks a tile number,
// turning each request into an accumulate operation or a no-op.
// ----------------------------------------------------------------------------
module hhcc_front #(
	parameter int SEGMENT_COUNT = 15,
	parameter int TILE_COUNT    = 34
) (
	input  hhcc_pkg::hit_t hit,
	output hhcc_pkg::op_t  op
);
	import hhcc_pkg::*;

	localparam int HALF16 = SEGMENT_COUNT * (PITCH16 / 2) + OFFSET16;
	localparam int SPAN16 = SEGMENT_COUNT * PITCH16;

	logic [20:0] pos;
	logic        pos_ok;
	logic [7:0]  coarse;
	logic [16:0] prod;
	logic        tile_ok;

	// Shift the span so that its first segment starts at zero
	assign pos    = {hit.x_position[19], hit.x_position} + 21'(HALF16);
	assign pos_ok = !pos[20] && (pos[19:0] < 20'(SPAN16));
	// Divide by the pitch: drop the power of two, then divide by seven
	assign coarse = pos[PITCH_SHIFT+7:PITCH_SHIFT];
	assign prod   = 17'(coarse) * 17'(DIV7_MUL);
	assign tile_ok = (7'(hit.tile_number) < 7'(TILE_COUNT));

	always_comb begin
		op.energy = hit.energy_kev;
		op.last   = hit.event_last;
		op.kind   = OP_NONE;
		op.index  = IDX_W'(hit.tile_number);
		if (hit.hit_present) begin
			if (!hit.detector) begin
				op.index = IDX_W'(prod[DIV7_SHIFT+4:DIV7_SHIFT]);
				if (pos_ok) op.kind = OP_SEG;
			end else if (tile_ok) begin
				op.kind = OP_TILE;
			end
		end
	end

endmodule

// ===== rtl/hhcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_back: energy sums, event evaluation and counters
// Accumulates hit energies, compares all sums at event end, forms the event
// flags and multiplicity and updates the saturating event counters.
// ----------------------------------------------------------------------------
module hhcc_back #(
	parameter int SEGMENT_COUNT = 15,
	parameter int TILE_COUNT    = 34,
	parameter int COUNTER_WIDTH = 32,
	parameter int ENERGY_WIDTH  = 16,
	parameter int OUT_CNT_W     = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hhcc_pkg::cfg_t        cfg,
	input  hhcc_pkg::op_t         op,
	input  logic                  op_empty,
	output logic                  op_pop,
	input  logic [OUT_CNT_W-1:0]  out_count,
	output logic                  res_push,
	output hhcc_pkg::result_t     res
);
	import hhcc_pkg::*;

	localparam int ADD_W  = ((ENERGY_WIDTH > 16) ? ENERGY_WIDTH : 16) + 1;
	localparam int CMP_W  = ADD_W - 1;
	localparam int MULT_W = $clog2(TILE_COUNT + 1);
	localparam int CR_W   = OUT_CNT_W + 1;
	localparam logic [ENERGY_WIDTH-1:0] EMAX = '1;

	localparam int CNT_SEL  = 0;
	localparam int CNT_MULT = 1;
	localparam int CNT_P20  = 2;
	localparam int CNT_P22  = 3;
	localparam int CNT_EDGE = 4;
	localparam int NCNT     = 5;

	logic take, take_last, credit_ok;
	logic [SEGMENT_COUNT-1:0] seg_ok, seg_in_range;
	logic [TILE_COUNT-1:0]    tile_ok;

	logic                     eval_s1;
	logic [SEGMENT_COUNT-1:0] seg_ok_s1;
	logic [TILE_COUNT-1:0]    tile_ok_s1;

	logic                     eval_s2;
	logic [NCNT-1:0]          flags_s2;
	logic [MULT_W-1:0]        mult_s2;

	logic [NCNT-1:0]          flags;
	logic [MULT_W-1:0]        mult;
	logic                     selected;

	logic [COUNTER_WIDTH-1:0] cnt_q    [NCNT];
	logic [COUNTER_WIDTH-1:0] cnt_next [NCNT];

	// Hold an event end until the result queue has room for every result in flight
	assign credit_ok = (CR_W'(out_count) + CR_W'(eval_s1) + CR_W'(eval_s2)) < CR_W'(OUT_DEPTH);
	assign op_pop    = !op_empty && (!op.last || credit_ok);
	assign take      = op_pop;
	assign take_last = take && op.last;

	for (genvar gi = 0; gi < SEGMENT_COUNT; gi++) begin : g_seg
		logic [ENERGY_WIDTH-1:0] sum_q, upd, cur;
		logic [ADD_W-1:0]        add;
		logic                    hit_here;

		assign hit_here = take && (op.kind == OP_SEG) && (op.index == IDX_W'(gi));
		assign add      = ADD_W'(sum_q) + ADD_W'(op.energy);
		assign upd      = (add > ADD_W'(EMAX)) ? EMAX : add[ENERGY_WIDTH-1:0];
		assign cur      = hit_here ? upd : sum_q;
		assign seg_ok[gi] = (CMP_W'(cur) >= CMP_W'(cfg.beam_threshold_kev));
		assign seg_in_range[gi] = (5'(cfg.segment_low) <= 5'(gi))
			&& (5'(gi) <= 5'(cfg.segment_high));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q <= '0;
			end else if (take_last) begin
				sum_q <= '0;
			end else if (hit_here) begin
				sum_q <= upd;
			end
		end
	end

	for (genvar gt = 0; gt < TILE_COUNT; gt++) begin : g_tile
		logic [ENERGY_WIDTH-1:0] sum_q, upd, cur;
		logic [ADD_W-1:0]        add;
		logic                    hit_here;

		assign hit_here = take && (op.kind == OP_TILE) && (op.index == IDX_W'(gt));
		assign add      = ADD_W'(sum_q) + ADD_W'(op.energy);
		assign upd      = (add > ADD_W'(EMAX)) ? EMAX : add[ENERGY_WIDTH-1:0];
		assign cur      = hit_here ? upd : sum_q;
		assign tile_ok[gt] = (CMP_W'(cur) >= CMP_W'(cfg.tile_threshold_kev));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q <= '0;
			end else if (take_last) begin
				sum_q <= '0;
			end else if (hit_here) begin
				sum_q <= upd;
			end
		end
	end

	// Stage 1: valid segments and tiles of the finished event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1 <= 1'b0;
			eval_s2 <= 1'b0;
		end else begin
			eval_s1 <= take_last;
			eval_s2 <= eval_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_last) begin
			seg_ok_s1  <= seg_ok;
			tile_ok_s1 <= tile_ok;
		end
	end

	// Stage 2: flags and multiplicity
	always_comb begin
		mult = '0;
		for (int i = 0; i < TILE_COUNT; i++) begin
			mult = mult + MULT_W'(tile_ok_s1[i]);
		end
	end

	assign selected = |(seg_ok_s1 & seg_in_range);

	always_comb begin
		flags = '0;
		flags[CNT_SEL]  = selected;
		flags[CNT_MULT] = selected && (mult >= MULT_W'(2));
		flags[CNT_P20]  = selected && tile_ok_s1[TILE_PAIR_LO_A] && tile_ok_s1[TILE_PAIR_LO_B];
		flags[CNT_P22]  = selected && tile_ok_s1[TILE_PAIR_HI_A] && tile_ok_s1[TILE_PAIR_HI_B];
		flags[CNT_EDGE] = selected && (|tile_ok_s1[TILE_EDGE_LAST:0])
			&& one_of_four(tile_ok_s1[TILE_PAIR_HI_B:TILE_PAIR_LO_A]);
	end

	always_ff @(posedge clk) begin
		if (eval_s1) begin
			flags_s2 <= flags;
			mult_s2  <= mult;
		end
	end

	// Stage 3: counter update and result push
	for (genvar gc = 0; gc < NCNT; gc++) begin : g_cnt
		assign cnt_next[gc] = (flags_s2[gc] && (cnt_q[gc] != '1))
			? cnt_q[gc] + COUNTER_WIDTH'(1) : cnt_q[gc];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[gc] <= '0;
			end else if (eval_s2) begin
				cnt_q[gc] <= cnt_next[gc];
			end
		end
	end

	assign res_push = eval_s2;

	always_comb begin
		res.event_selected     = flags_s2[CNT_SEL];
		res.multiplicity_two   = flags_s2[CNT_MULT];
		res.pair_twenty        = flags_s2[CNT_P20];
		res.pair_twentytwo     = flags_s2[CNT_P22];
		res.edge_single        = flags_s2[CNT_EDGE];
		res.tile_multiplicity  = 6'(mult_s2);
		res.count_selected     = 32'(cnt_next[CNT_SEL]);
		res.count_multiplicity = 32'(cnt_next[CNT_MULT]);
		res.count_pair_low     = 32'(cnt_next[CNT_P20]);
		res.count_pair_high    = 32'(cnt_next[CNT_P22]);
		res.count_edge         = 32'(cnt_next[CNT_EDGE]);
	end

endmodule

// ===== rtl/hodoscope_hit_coincidence_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hodoscope_hit_coincidence_counter: hodoscope hit coincidence counter
// Sums hit energies per beam-counter segment and per tile, evaluates each
// event at its last hit and keeps five saturating event counters.
// ----------------------------------------------------------------------------
// The block takes one hit per clock cycle with no gaps while the operation
// queue is not full. Each hit is classified on entry and placed in a
// four-entry operation queue; the back end adds its energy to one sum per
// cycle while the queue holds hits and, on the hit marked as the event's last,
// compares every sum against its threshold in that same cycle. The result for
// an event passes through the stage 1 and stage 2 registers of the back end
// into the four-entry result queue. An event's last hit waits in the operation
// queue while the result queue together with the results still in flight
// would exceed four entries, so a stalled reader slows intake only after
// about four events' worth of results are pending. Registers are written over
// the APB port at byte addresses 0, 4, 8 and 12 and should change only while
// no event is in flight.
module hodoscope_hit_coincidence_counter #(
	parameter int SEGMENT_COUNT = 15,
	parameter int TILE_COUNT    = 34,
	parameter int COUNTER_WIDTH = 32,
	parameter int ENERGY_WIDTH  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  hhcc_pkg::hit_t     hit,
	output logic               empty,
	input  logic               pop,
	output hhcc_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import hhcc_pkg::*;

	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	cfg_t    cfg_q;
	op_t     front_op, back_op;
	result_t back_res;
	logic    mid_empty, mid_pop, res_push, out_full;
	logic    cfg_write;
	logic [MID_CNT_W-1:0] mid_count;
	logic [OUT_CNT_W-1:0] out_count;

	// Register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segment_low        <= RST_SEGMENT_LOW;
			cfg_q.segment_high       <= RST_SEGMENT_HIGH;
			cfg_q.beam_threshold_kev <= RST_BEAM_THRESH;
			cfg_q.tile_threshold_kev <= RST_TILE_THRESH;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_SEGMENT_LOW:  cfg_q.segment_low        <= pwdata[3:0];
				REG_SEGMENT_HIGH: cfg_q.segment_high       <= pwdata[3:0];
				REG_BEAM_THRESH:  cfg_q.beam_threshold_kev <= pwdata[15:0];
				REG_TILE_THRESH:  cfg_q.tile_threshold_kev <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEGMENT_LOW:  prdata = 32'(cfg_q.segment_low);
			REG_SEGMENT_HIGH: prdata = 32'(cfg_q.segment_high);
			REG_BEAM_THRESH:  prdata = 32'(cfg_q.beam_threshold_kev);
			REG_TILE_THRESH:  prdata = 32'(cfg_q.tile_threshold_kev);
			default:          prdata = '0;
		endcase
	end

	hhcc_front #(
		.SEGMENT_COUNT (SEGMENT_COUNT),
		.TILE_COUNT    (TILE_COUNT)
	) u_front (
		.hit (hit),
		.op  (front_op)
	);

	hhcc_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (MID_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_op),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (back_op),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	hhcc_back #(
		.SEGMENT_COUNT (SEGMENT_COUNT),
		.TILE_COUNT    (TILE_COUNT),
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.ENERGY_WIDTH  (ENERGY_WIDTH),
		.OUT_CNT_W     (OUT_CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.op        (back_op),
		.op_empty  (mid_empty || (mid_count == '0)),
		.op_pop    (mid_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (back_res)
	);

	hhcc_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.count  (out_count)
	);

	// The credit check in the back end keeps the result queue from overflowing
	logic unused_out_full;
	assign unused_out_full = out_full;

endmodule

// ===== rtl/hhcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_checker: port-level checks of the coincidence counter
// Watches the result queue for reset behavior, flag consistency, head
// stability and the event counter sequence.
// ----------------------------------------------------------------------------
module hhcc_checker #(
	parameter int COUNTER_WIDTH = 32
) (
	input logic              clk,
	input logic              arst_n,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input hhcc_pkg::result_t result
);
	import hhcc_pkg::*;

	localparam logic [63:0] CNT_FULL = (64'd1 << COUNTER_WIDTH) - 64'd1;
	localparam logic [31:0] SEL_MAX  = 32'(CNT_FULL);
	localparam logic        CNT_FITS = (COUNTER_WIDTH <= 32);

	logic [31:0] last_sel_q;
	logic        seen_q;

	// Remember the selected count of the last result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sel_q <= '0;
			seen_q     <= 1'b0;
		end else if (pop && !empty) begin
			last_sel_q <= result.count_selected;
			seen_q     <= 1'b1;
		end
	end

	// Both queues come out of reset idle
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> (empty && !full))
		else $error("queues not idle after reset");

	a_flags_need_select: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.event_selected || !(result.multiplicity_two
			|| result.pair_twenty || result.pair_twentytwo || result.edge_single)))
		else $error("coincidence flag set on an unselected event");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before it was taken");

	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_FITS && seen_q && !empty && !result.event_selected)
		|-> (result.count_selected == last_sel_q))
		else $error("selected count moved on an unselected event");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_FITS && seen_q && !empty && result.event_selected && (last_sel_q != SEL_MAX))
		|-> (result.count_selected == last_sel_q + 32'd1))
		else $error("selected count did not advance by one");

endmodule

bind hodoscope_hit_coincidence_counter hhcc_checker #(
	.COUNTER_WIDTH (COUNTER_WIDTH)
) u_hhcc_checker (.*);

// ===== test/hhcc_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhcc_event_checker: event result predictor and comparator
// Watches the hit, result and register channels of the coincidence counter,
// keeps its own energy sums, thresholds and event counters, and compares each
// popped result field by field with the oldest predicted event.
// ----------------------------------------------------------------------------
module hhcc_event_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  hhcc_pkg::hit_t    hit,
	input  logic              pop,
	input  logic              empty,
	input  hhcc_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                pending
);
	import hhcc_pkg::*;

	localparam int SEGMENTS    = 15;
	localparam int TILES       = 34;
	localparam int SEG_PITCH   = 224;
	localparam int SEG_SHIFT   = 160 + SEGMENTS * SEG_PITCH / 2;
	localparam int MAX_REPORTS = 10;

	logic [15:0] seg_sum [SEGMENTS];
	logic [15:0] tile_sum [TILES];
	logic [31:0] n_selected, n_mult, n_pair_lo, n_pair_hi, n_edge;
	cfg_t        cfg;
	result_t     expected_events [$];

	function automatic logic [15:0] add_energy(input logic [15:0] sum, input logic [15:0] e);
		logic [16:0] s;
		s = {1'b0, sum} + {1'b0, e};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	function automatic void accumulate(input hit_t h);
		int p;
		if (!h.hit_present)
			return;
		if (h.detector == 1'b0) begin
			p = $signed(h.x_position) + SEG_SHIFT;
			// drop hits outside the hodoscope span
			if (p >= 0 && p < SEGMENTS * SEG_PITCH)
				seg_sum[p / SEG_PITCH] = add_energy(seg_sum[p / SEG_PITCH], h.energy_kev);
		end else if (h.tile_number < TILES) begin
			tile_sum[h.tile_number] = add_energy(tile_sum[h.tile_number], h.energy_kev);
		end
	endfunction

	function automatic result_t close_event();
		result_t          r;
		logic [TILES-1:0] valid;
		logic             sel;
		int               mult;
		int               quad;
		sel = 1'b0;
		for (int s = 0; s < SEGMENTS; s++)
			if (seg_sum[s] >= cfg.beam_threshold_kev && s >= cfg.segment_low &&
					s <= cfg.segment_high)
				sel = 1'b1;
		mult = 0;
		for (int t = 0; t < TILES; t++) begin
			valid[t] = tile_sum[t] >= cfg.tile_threshold_kev;
			mult += int'(valid[t]);
		end
		quad = int'(valid[20]) + int'(valid[21]) + int'(valid[22]) + int'(valid[23]);
		r = '0;
		r.event_selected    = sel;
		r.multiplicity_two  = sel && mult >= 2;
		r.pair_twenty       = sel && valid[20] && valid[21];
		r.pair_twentytwo    = sel && valid[22] && valid[23];
		r.edge_single       = sel && (|valid[5:0]) && quad == 1;
		r.tile_multiplicity = mult[5:0];
		if (r.event_selected)   n_selected = bump(n_selected);
		if (r.multiplicity_two) n_mult = bump(n_mult);
		if (r.pair_twenty)      n_pair_lo = bump(n_pair_lo);
		if (r.pair_twentytwo)   n_pair_hi = bump(n_pair_hi);
		if (r.edge_single)      n_edge = bump(n_edge);
		r.count_selected     = n_selected;
		r.count_multiplicity = n_mult;
		r.count_pair_low     = n_pair_lo;
		r.count_pair_high    = n_pair_hi;
		r.count_edge         = n_edge;
		// clear the sums for the next event
		for (int s = 0; s < SEGMENTS; s++) seg_sum[s] = '0;
		for (int t = 0; t < TILES; t++) tile_sum[t] = '0;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic compare_event(input result_t want, input result_t got);
		compare_field("event_selected", 32'(want.event_selected), 32'(got.event_selected));
		compare_field("multiplicity_two", 32'(want.multiplicity_two),
			32'(got.multiplicity_two));
		compare_field("pair_twenty", 32'(want.pair_twenty), 32'(got.pair_twenty));
		compare_field("pair_twentytwo", 32'(want.pair_twentytwo), 32'(got.pair_twentytwo));
		compare_field("edge_single", 32'(want.edge_single), 32'(got.edge_single));
		compare_field("tile_multiplicity", 32'(want.tile_multiplicity),
			32'(got.tile_multiplicity));
		compare_field("count_selected", want.count_selected, got.count_selected);
		compare_field("count_multiplicity", want.count_multiplicity, got.count_multiplicity);
		compare_field("count_pair_low", want.count_pair_low, got.count_pair_low);
		compare_field("count_pair_high", want.count_pair_high, got.count_pair_high);
		compare_field("count_edge", want.count_edge, got.count_edge);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int s = 0; s < SEGMENTS; s++) seg_sum[s] = '0;
			for (int t = 0; t < TILES; t++) tile_sum[t] = '0;
			n_selected = '0;
			n_mult     = '0;
			n_pair_lo  = '0;
			n_pair_hi  = '0;
			n_edge     = '0;
			cfg.segment_low        = RST_SEGMENT_LOW;
			cfg.segment_high       = RST_SEGMENT_HIGH;
			cfg.beam_threshold_kev = RST_BEAM_THRESH;
			cfg.tile_threshold_kev = RST_TILE_THRESH;
			expected_events.delete();
			mismatches = 0;
		end else begin
			// check the popped result before this edge's request can add one
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result popped with no event pending", $time);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					compare_event(want, result);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SEGMENT_LOW:  cfg.segment_low = pwdata[3:0];
					REG_SEGMENT_HIGH: cfg.segment_high = pwdata[3:0];
					REG_BEAM_THRESH:  cfg.beam_threshold_kev = pwdata[15:0];
					REG_TILE_THRESH:  cfg.tile_threshold_kev = pwdata[15:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				accumulate(hit);
				if (hit.event_last)
					expected_events.push_back(close_event());
			end
		end
		pending = expected_events.size();
	end

endmodule

// ===== test/hodoscope_hit_coincidence_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hodoscope_hit_coincidence_counter_test: coincidence counter testbench
// Drives directed and random hit sequences through the counter under several
// register settings, with random gaps on both sides and one long reader
// stall, while the event checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hodoscope_hit_coincidence_counter_test;
	import hhcc_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int PITCH        = 224;
	localparam int HALF_SPAN    = 1840;
	localparam int SPAN         = 3360;

	typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_BURSTY} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	hit_t        hit = '0;
	logic        full, empty, pready;
	result_t     result;
	logic [31:0] prdata;
	int          mismatches;
	int          pending;

	int          rx_hold = 0;
	int          idle_cycles = 0;
	pace_t       tx_pace = PACE_RANDOM;
	bit          tx_eager = 1'b0;
	logic [15:0] beam_thr = RST_BEAM_THRESH;
	logic [15:0] tile_thr = RST_TILE_THRESH;

	hodoscope_hit_coincidence_counter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.hit     (hit),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	hhcc_event_checker event_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hit        (hit),
		.pop        (pop),
		.empty      (empty),
		.result     (result),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int draw_gap(input pace_t pace);
		case (pace)
			PACE_STEADY: return 0;
			PACE_RANDOM: return $urandom_range(0, 18);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	function automatic hit_t make_hit(input logic det, input int x, input int tile,
			input int e, input logic present, input logic last);
		hit_t h;
		h.detector    = det;
		h.x_position  = x[19:0];
		h.tile_number = tile[5:0];
		h.energy_kev  = e[15:0];
		h.hit_present = present;
		h.event_last  = last;
		return h;
	endfunction

	function automatic hit_t rand_hit();
		hit_t h;
		int   x, t, e, lim;
		h = '0;
		h.hit_present = ($urandom_range(0, 15) != 0);
		h.detector    = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: x = int'($urandom_range(0, SPAN - 1)) - HALF_SPAN;
			// straddle either end of the span
			6: x = ($urandom_range(0, 1) ? SPAN - HALF_SPAN - 1 : -HALF_SPAN) +
					int'($urandom_range(0, 2)) - 1;
			7: x = int'($urandom_range(4 * PITCH, 11 * PITCH - 1)) - HALF_SPAN;
			default: x = int'($urandom_range(0, 20'hFFFFF)) - 524288;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: t = $urandom_range(0, 5);
			3, 4, 5: t = $urandom_range(20, 23);
			6, 7, 8: t = $urandom_range(0, 33);
			default: t = $urandom_range(0, 63);
		endcase
		lim = h.detector ? int'(tile_thr) : int'(beam_thr);
		lim = lim + lim / 4 + 1;
		if (lim > 65535)
			lim = 65535;
		case ($urandom_range(0, 7))
			0: e = 65535;
			1: e = 0;
			2, 3: e = $urandom_range(0, 65535);
			default: e = $urandom_range(0, lim);
		endcase
		h.x_position  = x[19:0];
		h.tile_number = t[5:0];
		h.energy_kev  = e[15:0];
		return h;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with push still high, so a back-to-back request needs no gap.
	task automatic send_hit(input hit_t h);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_pace = pace_t'($urandom_range(0, 2));
		gap = tx_eager ? 0 : draw_gap(tx_pace);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		hit  <= h;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [3:0] lo, input logic [3:0] hi,
			input logic [15:0] bthr, input logic [15:0] tthr);
		push <= 1'b0;
		wait (pending == 0);
		// let trailing requests without a result leave the pipeline
		repeat (DRAIN_CYCLES) @(negedge clk);
		reg_write(REG_SEGMENT_LOW, {28'd0, lo});
		reg_write(REG_SEGMENT_HIGH, {28'd0, hi});
		reg_write(REG_BEAM_THRESH, {16'd0, bthr});
		reg_write(REG_TILE_THRESH, {16'd0, tthr});
		beam_thr = bthr;
		tile_thr = tthr;
	endtask

	task automatic random_events(input int n);
		int          sent, len;
		hit_t        h;
		logic [63:0] raw;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 6) == 0) begin
				// noise: any bit pattern, possibly breaking an event
				raw = {$urandom(), $urandom()};
				h = raw[$bits(hit_t)-1:0];
				send_hit(h);
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					h = rand_hit();
					h.event_last = (k == len - 1);
					send_hit(h);
					sent++;
				end
			end
		end
	endtask

	initial begin : result_reader
		pace_t pace;
		int    gap;
		pace = PACE_RANDOM;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				pace = pace_t'($urandom_range(0, 2));
			gap = draw_gap(pace);
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed events under the reset settings
		send_hit(make_hit(1'b1, 0, 20, 65535, 1'b0, 1'b1));
		send_hit(make_hit(1'b0, -524288, 0, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, 524287, 0, 65535, 1'b1, 1'b1));
		send_hit(make_hit(1'b0, -HALF_SPAN - 1, 0, 500, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, SPAN - HALF_SPAN, 0, 500, 1'b1, 1'b1));
		send_hit(make_hit(1'b0, -HALF_SPAN, 0, 500, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, SPAN - HALF_SPAN - 1, 0, 500, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, 0, 0, 0, 1'b0, 1'b1));
		send_hit(make_hit(1'b1, 0, 63, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 34, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 33, 300, 1'b1, 1'b1));
		// both pairs and a threshold hit exactly on the beam threshold
		send_hit(make_hit(1'b0, 4 * PITCH - HALF_SPAN, 0, 100, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 20, 200, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 21, 200, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 22, 200, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 23, 200, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 5, 200, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 0, 65535, 1'b1, 1'b1));
		// edge single built from split energies at the top selected segment
		send_hit(make_hit(1'b0, 11 * PITCH - HALF_SPAN - 1, 0, 60, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, 11 * PITCH - HALF_SPAN - 1, 0, 40, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 2, 150, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 2, 50, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 22, 200, 1'b1, 1'b1));
		// saturating sums just outside the selected segments
		send_hit(make_hit(1'b0, 3 * PITCH - HALF_SPAN, 0, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 21, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b1, 0, 21, 65535, 1'b1, 1'b0));
		send_hit(make_hit(1'b0, 11 * PITCH - HALF_SPAN, 0, 65535, 1'b1, 1'b1));

		random_events(250);
		set_config(4'd0, 4'd14, 16'd0, 16'd0);
		random_events(150);
		set_config(4'd14, 4'd0, 16'hFFFF, 16'hFFFF);
		random_events(150);
		set_config(4'd0, 4'd0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		random_events(200);
		set_config(4'd14, 4'd14, 16'd300, 16'd300);
		random_events(200);
		set_config(4'd7, 4'd7, 16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
		random_events(200);

		// hold the reader off while requests keep coming to fill the block
		rx_hold  = HOLD_CYCLES;
		tx_eager = 1'b1;
		random_events(120);
		tx_eager = 1'b0;

		set_config(4'($urandom_range(0, 14)), 4'($urandom_range(0, 14)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 2000)));
		random_events(250);
		set_config(RST_SEGMENT_LOW, RST_SEGMENT_HIGH, RST_BEAM_THRESH, RST_TILE_THRESH);
		random_events(250);

		push <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
